>>> rtl/qrs_pkg.sv
// Shared widths, result codes, side-band types and the saturation function
// of the quadratic root solver. No dependencies.
`default_nettype none

package qrs_pkg;

    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 16;
    localparam int CNT_W     = 2;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = PROD_W + 3;
    localparam int DMAG_W    = PROD_W + 2;
    localparam int ROOT_W    = DMAG_W / 2;
    localparam int NUM_W     = ROOT_W + 1;
    localparam int DEN_W     = COEF_W + 1;
    localparam int QUOT_W    = COEF_W;
    localparam int DIV_HI_W  = NUM_W + FRAC_BITS - QUOT_W;

    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
    localparam logic [CNT_W-1:0] CNT_INF  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_INF,
        KIND_LIN,
        KIND_DBL,
        KIND_TWO
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } t_coef_side;

    typedef struct packed {
        t_kind kind;
        logic  neg;
    } t_div_side;

    typedef struct packed {
        logic                     ovf;
        logic signed [COEF_W-1:0] root;
    } t_sat_root;

    function automatic t_sat_root saturate(input logic [QUOT_W-1:0] q, input logic big,
                                           input logic neg);
        t_sat_root r;
        r.ovf  = 1'b0;
        r.root = '0;
        if (neg) begin
            if (big || (q[QUOT_W-1] && (q[QUOT_W-2:0] != '0))) begin
                r.ovf  = 1'b1;
                r.root = {1'b1, {(COEF_W-1){1'b0}}};
            end else begin
                r.root = '0 - q;
            end
        end else begin
            if (big || q[QUOT_W-1]) begin
                r.ovf  = 1'b1;
                r.root = {1'b0, {(COEF_W-1){1'b1}}};
            end else begin
                r.root = q;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/quadratic_root_solver_unit.sv
// Quadratic root solver for a*x^2 + b*x + c = 0 in signed Q16.16.
// Instantiates qrs_front, qrs_sqrt and qrs_div; uses qrs_pkg.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one request of
// three coefficients; the output channel (o_out_valid / i_out_ready) returns
// one result per request: root count, low and high root, overflow flag.
// The tolerance register is written through i_cfg_valid / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// o_cfg_ready is always high. Reset sets it to 1. The pipeline has four front
// stages (magnitudes, products, discriminant, classification), 33 square-root
// stages (one root bit each), one numerator stage, 33 divider stages (a range
// check and one quotient bit each) and the output register. Throughput is one
// request per cycle while o_in_ready is high. When the receiver stalls, the
// result is held and a second result goes into a skid register; only while
// that register is full does the pipeline stop and o_in_ready fall, and
// nothing is lost or repeated. Synchronous reset empties the pipeline.
`default_nettype none

module quadratic_root_solver_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_c,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [qrs_pkg::CNT_W-1:0]              o_root_count,
    output logic signed [qrs_pkg::COEF_W-1:0]      o_root_low,
    output logic signed [qrs_pkg::COEF_W-1:0]      o_root_high,
    output logic                                   o_overflow,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [qrs_pkg::TOL_W-1:0]         i_cfg_data
);

    typedef struct packed {
        logic [qrs_pkg::CNT_W-1:0]         cnt;
        logic signed [qrs_pkg::COEF_W-1:0] lo;
        logic signed [qrs_pkg::COEF_W-1:0] hi;
        logic                              ovf;
    } t_result;

    localparam int NW = qrs_pkg::NUM_W + 1;
    localparam int CW = qrs_pkg::COEF_W;

    logic [qrs_pkg::TOL_W-1:0] r_tol;
    logic                      w_en;

    logic                       w_fr_valid;
    logic [qrs_pkg::DMAG_W-1:0] w_fr_dmag;
    qrs_pkg::t_coef_side        w_fr_side;

    logic                       w_sq_valid;
    logic [qrs_pkg::ROOT_W-1:0] w_sq_root;
    qrs_pkg::t_coef_side        w_sq_side;

    logic signed [NW-1:0]             w_seff, w_negb, w_negc, w_n1, w_n2;
    logic signed [qrs_pkg::DEN_W-1:0] w_d;
    logic                             w_is_lin;

    logic                        r_n_valid;
    logic [qrs_pkg::NUM_W-1:0]   r_n_num1, r_n_num2;
    logic [qrs_pkg::DEN_W-1:0]   r_n_den;
    qrs_pkg::t_div_side          r_n_side;
    logic                        r_n_neg2;

    logic                        w_d0_valid, w_d1_valid, w_d0_big, w_d1_big, w_d1_neg;
    logic [qrs_pkg::QUOT_W-1:0]  w_d0_quot, w_d1_quot;
    qrs_pkg::t_div_side          w_d0_side;

    qrs_pkg::t_sat_root w_r1, w_r2;
    t_result            w_res;
    logic               w_tail_valid;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign w_en        = !r_skid_valid;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_W'(1);
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    qrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .i_tol    (r_tol),
        .o_valid  (w_fr_valid),
        .o_dmag   (w_fr_dmag),
        .o_side   (w_fr_side)
    );

    qrs_sqrt #(
        .SIDE_W ($bits(qrs_pkg::t_coef_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fr_valid),
        .i_rad   (w_fr_dmag),
        .i_side  (w_fr_side),
        .o_valid (w_sq_valid),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign w_is_lin = (w_sq_side.kind == qrs_pkg::KIND_LIN);
    assign w_seff   = (w_sq_side.kind == qrs_pkg::KIND_TWO) ? NW'(w_sq_root) : '0;
    assign w_negb   = '0 - {{(NW-CW){w_sq_side.b[CW-1]}}, w_sq_side.b};
    assign w_negc   = '0 - {{(NW-CW){w_sq_side.c[CW-1]}}, w_sq_side.c};
    assign w_n1     = w_is_lin ? w_negc : (w_negb - w_seff);
    assign w_n2     = w_negb + w_seff;
    assign w_d      = w_is_lin ? {w_sq_side.b[CW-1], w_sq_side.b} : {w_sq_side.a, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_en) begin
            r_n_valid <= w_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_num1      <= w_n1[NW-1] ? qrs_pkg::NUM_W'('0 - w_n1) : w_n1[NW-2:0];
            r_n_num2      <= w_n2[NW-1] ? qrs_pkg::NUM_W'('0 - w_n2) : w_n2[NW-2:0];
            r_n_den       <= w_d[qrs_pkg::DEN_W-1] ? ('0 - w_d) : w_d;
            r_n_side.kind <= w_sq_side.kind;
            r_n_side.neg  <= w_n1[NW-1] ^ w_d[qrs_pkg::DEN_W-1];
            r_n_neg2      <= w_n2[NW-1] ^ w_d[qrs_pkg::DEN_W-1];
        end
    end

    qrs_div #(
        .SIDE_W ($bits(qrs_pkg::t_div_side))
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_valid),
        .i_num   (r_n_num1),
        .i_den   (r_n_den),
        .i_side  (r_n_side),
        .o_valid (w_d0_valid),
        .o_quot  (w_d0_quot),
        .o_big   (w_d0_big),
        .o_side  (w_d0_side)
    );

    qrs_div #(
        .SIDE_W (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_n_valid),
        .i_num   (r_n_num2),
        .i_den   (r_n_den),
        .i_side  (r_n_neg2),
        .o_valid (w_d1_valid),
        .o_quot  (w_d1_quot),
        .o_big   (w_d1_big),
        .o_side  (w_d1_neg)
    );

    assign w_r1         = qrs_pkg::saturate(w_d0_quot, w_d0_big, w_d0_side.neg);
    assign w_r2         = qrs_pkg::saturate(w_d1_quot, w_d1_big, w_d1_neg);
    assign w_tail_valid = w_d0_valid & w_d1_valid;

    always_comb begin
        w_res = '0;
        case (w_d0_side.kind)
            qrs_pkg::KIND_INF: begin
                w_res.cnt = qrs_pkg::CNT_INF;
            end
            qrs_pkg::KIND_LIN: begin
                w_res.cnt = qrs_pkg::CNT_ONE;
                w_res.lo  = w_r1.root;
                w_res.ovf = w_r1.ovf;
            end
            qrs_pkg::KIND_DBL: begin
                w_res.cnt = qrs_pkg::CNT_ONE;
                w_res.lo  = w_r1.root;
                w_res.hi  = w_r1.root;
                w_res.ovf = w_r1.ovf;
            end
            qrs_pkg::KIND_TWO: begin
                w_res.cnt = qrs_pkg::CNT_TWO;
                w_res.lo  = (w_r1.root < w_r2.root) ? w_r1.root : w_r2.root;
                w_res.hi  = (w_r1.root < w_r2.root) ? w_r2.root : w_r1.root;
                w_res.ovf = w_r1.ovf | w_r2.ovf;
            end
            default: begin
                w_res.cnt = qrs_pkg::CNT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= w_tail_valid;
        end else if (w_tail_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || i_out_ready) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_root_count = r_out.cnt;
    assign o_root_low   = r_out.lo;
    assign o_root_high  = r_out.hi;
    assign o_overflow   = r_out.ovf;

endmodule

`default_nettype wire

>>> rtl/qrs_front.sv
// Front end: coefficient magnitudes, zero tests, the two products and the
// exact discriminant with its classification. Uses qrs_pkg.
`default_nettype none

module qrs_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_a,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_b,
    input  wire logic signed [qrs_pkg::COEF_W-1:0] i_coef_c,
    input  wire logic [qrs_pkg::TOL_W-1:0]        i_tol,
    output logic                                  o_valid,
    output logic [qrs_pkg::DMAG_W-1:0]            o_dmag,
    output qrs_pkg::t_coef_side                   o_side
);

    logic [qrs_pkg::COEF_W-1:0] w_amag, w_bmag, w_cmag, w_tol_ext;

    logic                              r1_valid, r2_valid, r3_valid, r4_valid;
    logic [qrs_pkg::COEF_W-1:0]        r1_amag, r1_bmag, r1_cmag;
    logic signed [qrs_pkg::COEF_W-1:0] r1_a, r1_b, r1_c, r2_a, r2_b, r2_c, r3_a, r3_b, r3_c;
    logic                              r1_az, r1_bz, r1_cz, r2_az, r2_bz, r2_cz, r3_az, r3_bz, r3_cz;
    logic [qrs_pkg::PROD_W-1:0]        r2_bb, r2_ac;
    logic                              r2_acneg;
    logic [qrs_pkg::DISC_W-1:0]        r3_disc;
    logic [qrs_pkg::DMAG_W-1:0]        r4_dmag;
    qrs_pkg::t_coef_side               r4_side;

    logic [qrs_pkg::DISC_W-1:0] w_bb_ext, w_4ac, w_dabs;
    logic [qrs_pkg::DMAG_W-1:0] w_dmag, w_zt;
    logic                       w_dneg;
    qrs_pkg::t_kind             w_kind;

    assign w_amag    = i_coef_a[qrs_pkg::COEF_W-1] ? (~i_coef_a + 1'b1) : i_coef_a;
    assign w_bmag    = i_coef_b[qrs_pkg::COEF_W-1] ? (~i_coef_b + 1'b1) : i_coef_b;
    assign w_cmag    = i_coef_c[qrs_pkg::COEF_W-1] ? (~i_coef_c + 1'b1) : i_coef_c;
    assign w_tol_ext = qrs_pkg::COEF_W'(i_tol);

    assign w_bb_ext = {3'b000, r2_bb};
    assign w_4ac    = {1'b0, r2_ac, 2'b00};

    assign w_dneg = r3_disc[qrs_pkg::DISC_W-1];
    assign w_dabs = w_dneg ? (~r3_disc + 1'b1) : r3_disc;
    assign w_dmag = w_dabs[qrs_pkg::DMAG_W-1:0];
    assign w_zt   = qrs_pkg::DMAG_W'({i_tol, {qrs_pkg::FRAC_BITS{1'b0}}});

    always_comb begin
        if (r3_az) begin
            if (r3_bz) begin
                w_kind = r3_cz ? qrs_pkg::KIND_INF : qrs_pkg::KIND_NONE;
            end else begin
                w_kind = qrs_pkg::KIND_LIN;
            end
        end else if (w_dmag <= w_zt) begin
            w_kind = qrs_pkg::KIND_DBL;
        end else if (w_dneg) begin
            w_kind = qrs_pkg::KIND_NONE;
        end else begin
            w_kind = qrs_pkg::KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_amag  <= w_amag;
            r1_bmag  <= w_bmag;
            r1_cmag  <= w_cmag;
            r1_a     <= i_coef_a;
            r1_b     <= i_coef_b;
            r1_c     <= i_coef_c;
            r1_az    <= (w_amag <= w_tol_ext);
            r1_bz    <= (w_bmag <= w_tol_ext);
            r1_cz    <= (w_cmag <= w_tol_ext);

            r2_bb    <= r1_bmag * r1_bmag;
            r2_ac    <= r1_amag * r1_cmag;
            r2_acneg <= r1_a[qrs_pkg::COEF_W-1] ^ r1_c[qrs_pkg::COEF_W-1];
            r2_a     <= r1_a;
            r2_b     <= r1_b;
            r2_c     <= r1_c;
            r2_az    <= r1_az;
            r2_bz    <= r1_bz;
            r2_cz    <= r1_cz;

            r3_disc  <= r2_acneg ? (w_bb_ext + w_4ac) : (w_bb_ext - w_4ac);
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_c     <= r2_c;
            r3_az    <= r2_az;
            r3_bz    <= r2_bz;
            r3_cz    <= r2_cz;

            r4_dmag      <= w_dmag;
            r4_side.kind <= w_kind;
            r4_side.a    <= r3_a;
            r4_side.b    <= r3_b;
            r4_side.c    <= r3_c;
        end
    end

    assign o_valid = r4_valid;
    assign o_dmag  = r4_dmag;
    assign o_side  = r4_side;

endmodule

`default_nettype wire

>>> rtl/qrs_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage, with a
// side-band word carried alongside. Uses qrs_pkg.
`default_nettype none

module qrs_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [qrs_pkg::DMAG_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0]            i_side,
    output logic                              o_valid,
    output logic [qrs_pkg::ROOT_W-1:0]        o_root,
    output logic [SIDE_W-1:0]                 o_side
);

    localparam int RW = qrs_pkg::ROOT_W;
    localparam int DW = qrs_pkg::DMAG_W;

    logic          r_valid [RW];
    logic [RW+1:0] r_rem   [RW];
    logic [RW-1:0] r_root  [RW];
    logic [DW-1:0] r_rad   [RW];
    logic [SIDE_W-1:0] r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              pv;
        logic [RW+1:0]     prem;
        logic [RW-1:0]     proot;
        logic [DW-1:0]     prad;
        logic [SIDE_W-1:0] pside;
        logic [RW+1:0]     w_cur, w_trial, w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign prem  = '0;
            assign proot = '0;
            assign prad  = i_rad;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_valid[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign prad  = r_rad[k-1];
            assign pside = r_side[k-1];
        end

        assign w_cur   = {prem[RW-1:0], prad[DW-1 -: 2]};
        assign w_trial = {proot, 2'b01};
        assign w_ge    = (w_cur >= w_trial);
        assign w_diff  = w_cur - w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff : w_cur;
                r_root[k] <= {proot[RW-2:0], w_ge};
                r_rad[k]  <= {prad[DW-3:0], 2'b00};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_valid[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

`default_nettype wire

>>> rtl/qrs_div.sv
// Pipelined restoring divider for fixed-point quotients: an entry stage that
// flags quotients too wide for the word, then one quotient bit per stage.
// Uses qrs_pkg.
`default_nettype none

module qrs_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [qrs_pkg::NUM_W-1:0]   i_num,
    input  wire logic [qrs_pkg::DEN_W-1:0]   i_den,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic                             o_valid,
    output logic [qrs_pkg::QUOT_W-1:0]       o_quot,
    output logic                             o_big,
    output logic [SIDE_W-1:0]                o_side
);

    localparam int QW = qrs_pkg::QUOT_W;
    localparam int EW = qrs_pkg::DEN_W;
    localparam int HW = qrs_pkg::DIV_HI_W;

    logic [HW-1:0] w_hi;

    logic              r_e_valid, r_e_big;
    logic [EW-1:0]     r_e_rem, r_e_den;
    logic [QW-1:0]     r_e_lo;
    logic [SIDE_W-1:0] r_e_side;

    logic              r_valid [QW];
    logic              r_big   [QW];
    logic [EW-1:0]     r_rem   [QW];
    logic [EW-1:0]     r_den   [QW];
    logic [QW-1:0]     r_lo    [QW];
    logic [QW-1:0]     r_quot  [QW];
    logic [SIDE_W-1:0] r_side  [QW];

    assign w_hi = i_num[qrs_pkg::NUM_W-1 -: HW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_big  <= (EW'(w_hi) >= i_den);
            r_e_rem  <= EW'(w_hi);
            r_e_den  <= i_den;
            r_e_lo   <= {i_num[qrs_pkg::NUM_W-HW-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
            r_e_side <= i_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              pv, pbig;
        logic [EW-1:0]     prem, pden;
        logic [QW-1:0]     plo, pquot;
        logic [SIDE_W-1:0] pside;
        logic [EW:0]       w_cur, w_diff;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign pv    = r_e_valid;
            assign pbig  = r_e_big;
            assign prem  = r_e_rem;
            assign pden  = r_e_den;
            assign plo   = r_e_lo;
            assign pquot = '0;
            assign pside = r_e_side;
        end else begin : g_next
            assign pv    = r_valid[k-1];
            assign pbig  = r_big[k-1];
            assign prem  = r_rem[k-1];
            assign pden  = r_den[k-1];
            assign plo   = r_lo[k-1];
            assign pquot = r_quot[k-1];
            assign pside = r_side[k-1];
        end

        assign w_cur  = {prem, plo[QW-1]};
        assign w_ge   = (w_cur >= {1'b0, pden});
        assign w_diff = w_cur - {1'b0, pden};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_big[k]  <= pbig;
                r_rem[k]  <= w_ge ? w_diff[EW-1:0] : w_cur[EW-1:0];
                r_den[k]  <= pden;
                r_lo[k]   <= {plo[QW-2:0], 1'b0};
                r_quot[k] <= {pquot[QW-2:0], w_ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_big   = r_big[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire
